### sv/hsvrgb_pkg.sv
// Shared constants, types and helpers for the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

    localparam int unsigned SECTOR_SPAN = 3840;
    localparam int unsigned SECTOR_LAST = 8;

    localparam logic [11:0] SPAN_VAL = 12'd3840;
    localparam logic [27:0] ONE_VAL  = 28'd251658240;
    localparam logic [7:0]  CHAN_MAX = 8'd255;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    typedef logic [16:0] frac_t;
    typedef logic [27:0] scale_t;
    typedef logic [28:0] sprod_t;
    typedef logic [44:0] chan_prod_t;

    function automatic logic [14:0] sector_base(input logic [3:0] k);
        return 15'(k * SECTOR_SPAN);
    endfunction

endpackage

`default_nettype wire

### sv/hsvrgb_chan_scale.sv
// One output channel: brightness times scale, then floor(x*255) with saturation.
`default_nettype none

module hsvrgb_chan_scale (
    input  wire logic                    clk,
    input  wire hsvrgb_pkg::frac_t       brightness,
    input  wire hsvrgb_pkg::scale_t      scale,
    output logic [7:0]                   chan
);

    hsvrgb_pkg::chan_prod_t prod_reg;
    hsvrgb_pkg::chan_prod_t prod_next;
    logic [49:0]            scaled;
    logic [7:0]             chan_reg;
    logic [7:0]             chan_next;

    assign prod_next = 45'(brightness) * 45'(scale);

    // x*255 / (15 * 2^40) == x*17 / 2^40
    assign scaled    = {1'b0, prod_reg, 4'b0000} + {5'b00000, prod_reg};
    assign chan_next = (scaled[49:48] != 2'b00) ? hsvrgb_pkg::CHAN_MAX : scaled[47:40];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

### sv/hsv_to_rgb_converter_core.sv
// Top level of the pipelined HSV to RGB converter.
// Usage:
//   Drive hue, saturation and brightness and raise start for one cycle per
//   transaction. busy is always low: a new transaction may be issued in
//   every cycle, so one color per clock is sustained.
//   After a transaction is accepted and has passed through the pipeline,
//   red, green and blue are shown for exactly one cycle with done high. The
//   receiver must take the result in that cycle; there is no back-pressure.
//   Stages: sector split, three saturation products, scale select and
//   clamp, brightness multiply, channel scaling and saturation.
//   Zero saturation gives grey; hue of 360 degrees or above uses the last
//   sector; saturation above 1.0 can drive channels to 0 and brightness
//   above 1.0 saturates them at 255.
//   rst_n clears the stage valid bits, so done stays low until new
//   transactions have passed through the pipeline.
`default_nettype none

module hsv_to_rgb_converter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [14:0] hue,
    input  wire logic [16:0] saturation,
    input  wire logic [16:0] brightness,
    output logic             done,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue
);

    logic [4:0] valid_reg;
    logic [4:0] valid_next;

    logic [3:0]  k_next;
    logic [2:0]  s1_sec_reg;
    logic [2:0]  s1_sec_next;
    logic [11:0] s1_rem_reg;
    logic [11:0] s1_rem_next;
    hsvrgb_pkg::frac_t s1_sat_reg;
    hsvrgb_pkg::frac_t s1_bri_reg;

    logic [2:0]             s2_sec_reg;
    hsvrgb_pkg::frac_t      s2_bri_reg;
    hsvrgb_pkg::sprod_t     s2_sxq_reg;
    hsvrgb_pkg::sprod_t     s2_sxq_next;
    hsvrgb_pkg::sprod_t     s2_sxt_reg;
    hsvrgb_pkg::sprod_t     s2_sxt_next;
    hsvrgb_pkg::sprod_t     s2_sxp_reg;
    hsvrgb_pkg::sprod_t     s2_sxp_next;

    hsvrgb_pkg::scale_t a_q;
    hsvrgb_pkg::scale_t a_t;
    hsvrgb_pkg::scale_t a_p;
    hsvrgb_pkg::scale_t s3_r_reg;
    hsvrgb_pkg::scale_t s3_r_next;
    hsvrgb_pkg::scale_t s3_g_reg;
    hsvrgb_pkg::scale_t s3_g_next;
    hsvrgb_pkg::scale_t s3_b_reg;
    hsvrgb_pkg::scale_t s3_b_next;
    hsvrgb_pkg::frac_t  s3_bri_reg;

    function automatic hsvrgb_pkg::scale_t clamp_scale(input hsvrgb_pkg::sprod_t sx);
        logic [29:0] diff;
        diff = {2'b00, hsvrgb_pkg::ONE_VAL} - {1'b0, sx};
        if (diff[29] || diff == 30'd0)
            return '0;
        return diff[27:0];
    endfunction

    // stage 1: sector and remainder
    always_comb
    begin
        k_next = 4'd0;
        for (int i = 1; i <= hsvrgb_pkg::SECTOR_LAST; i++)
        begin
            if (hue >= 15'(i * hsvrgb_pkg::SECTOR_SPAN))
                k_next = 4'(i);
        end
        s1_rem_next = 12'(hue - hsvrgb_pkg::sector_base(k_next));
        s1_sec_next = (k_next >= 4'd5) ? hsvrgb_pkg::SEC_5 : k_next[2:0];
    end

    // stage 2: saturation products
    assign s2_sxq_next = 29'(s1_sat_reg) * 29'(s1_rem_reg);
    assign s2_sxt_next = 29'(s1_sat_reg) * 29'(hsvrgb_pkg::SPAN_VAL - s1_rem_reg);
    assign s2_sxp_next = 29'(s1_sat_reg) * 29'(hsvrgb_pkg::SPAN_VAL);

    // stage 3: clamp and permute
    assign a_q = clamp_scale(s2_sxq_reg);
    assign a_t = clamp_scale(s2_sxt_reg);
    assign a_p = clamp_scale(s2_sxp_reg);

    always_comb
    begin
        case (s2_sec_reg)
            hsvrgb_pkg::SEC_0:
            begin
                s3_r_next = hsvrgb_pkg::ONE_VAL; s3_g_next = a_t; s3_b_next = a_p;
            end
            hsvrgb_pkg::SEC_1:
            begin
                s3_r_next = a_q; s3_g_next = hsvrgb_pkg::ONE_VAL; s3_b_next = a_p;
            end
            hsvrgb_pkg::SEC_2:
            begin
                s3_r_next = a_p; s3_g_next = hsvrgb_pkg::ONE_VAL; s3_b_next = a_t;
            end
            hsvrgb_pkg::SEC_3:
            begin
                s3_r_next = a_p; s3_g_next = a_q; s3_b_next = hsvrgb_pkg::ONE_VAL;
            end
            hsvrgb_pkg::SEC_4:
            begin
                s3_r_next = a_t; s3_g_next = a_p; s3_b_next = hsvrgb_pkg::ONE_VAL;
            end
            default:
            begin
                s3_r_next = hsvrgb_pkg::ONE_VAL; s3_g_next = a_p; s3_b_next = a_q;
            end
        endcase
    end

    assign valid_next = {valid_reg[3:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        s1_sec_reg <= s1_sec_next;
        s1_rem_reg <= s1_rem_next;
        s1_sat_reg <= saturation;
        s1_bri_reg <= brightness;

        s2_sec_reg <= s1_sec_reg;
        s2_bri_reg <= s1_bri_reg;
        s2_sxq_reg <= s2_sxq_next;
        s2_sxt_reg <= s2_sxt_next;
        s2_sxp_reg <= s2_sxp_next;

        s3_r_reg   <= s3_r_next;
        s3_g_reg   <= s3_g_next;
        s3_b_reg   <= s3_b_next;
        s3_bri_reg <= s2_bri_reg;
    end

    // stages 4 and 5
    hsvrgb_chan_scale u_red (
        .clk        (clk),
        .brightness (s3_bri_reg),
        .scale      (s3_r_reg),
        .chan       (red)
    );

    hsvrgb_chan_scale u_green (
        .clk        (clk),
        .brightness (s3_bri_reg),
        .scale      (s3_g_reg),
        .chan       (green)
    );

    hsvrgb_chan_scale u_blue (
        .clk        (clk),
        .brightness (s3_bri_reg),
        .scale      (s3_b_reg),
        .chan       (blue)
    );

    assign done = valid_reg[4];
    assign busy = 1'b0;

endmodule

`default_nettype wire

### sv/hsv_to_rgb_converter_core_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
`default_nettype none

module hsv_to_rgb_converter_core_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [16:0] saturation,
    input wire logic [16:0] brightness,
    input wire logic        done,
    input wire logic [7:0]  red,
    input wire logic [7:0]  green,
    input wire logic [7:0]  blue
);

    logic [2:0] up_cnt_reg;
    logic [2:0] up_cnt_next;

    assign up_cnt_next = (up_cnt_reg == 3'd5) ? up_cnt_reg : up_cnt_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            up_cnt_reg <= '0;
        else
            up_cnt_reg <= up_cnt_next;
    end

    // done marks exactly the accepted transactions, once the warm-up counter has saturated
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (up_cnt_reg == 3'd5) |-> (done == $past(start && !busy, 5)))
        else $error("done does not match transaction five cycles earlier");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && brightness == 17'd0) |-> ##5
        (red == 8'd0 && green == 8'd0 && blue == 8'd0))
        else $error("zero brightness must give black");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && saturation == 17'd0) |-> ##5
        (red == green && green == blue))
        else $error("zero saturation must give grey");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && saturation == 17'd65536 && brightness == 17'd65536) |-> ##5
        ((red == 8'd255 || green == 8'd255 || blue == 8'd255) &&
         (red == 8'd0 || green == 8'd0 || blue == 8'd0)))
        else $error("full saturation and brightness must span 0 to 255");

endmodule

bind hsv_to_rgb_converter_core hsv_to_rgb_converter_core_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
);

`default_nettype wire

### dv/hsv_to_rgb_converter_core_tb.sv
// Self-checking testbench for the HSV to RGB converter core.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core_tb;

    localparam longint SPAN           = hsvrgb_pkg::SECTOR_SPAN;
    localparam longint FRAC_ONE       = 65536;
    localparam longint CHAN_TOP       = hsvrgb_pkg::CHAN_MAX;
    localparam int     SETTLE_CYCLES  = 10;
    localparam int     WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [14:0] hue;
    logic [16:0] saturation;
    logic [16:0] brightness;
    logic        done;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    rgb_t rgb_expected_q[$];
    rgb_t oldest_rgb;
    int   mismatch_count = 0;
    int   idle_cycles = 0;

    hsv_to_rgb_converter_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // numerator over 2^32 * SPAN -> floor(x*255), saturated
    function automatic logic [7:0] scale_channel(input longint num);
        longint c;
        if (num < 0)
            return 8'd0;
        c = (num * CHAN_TOP) / (SPAN <<< 32);
        if (c > CHAN_TOP)
            c = CHAN_TOP;
        return 8'(c);
    endfunction

    function automatic rgb_t predict_rgb(input logic [14:0] h, input logic [16:0] s,
                                         input logic [16:0] v);
        longint     hh, ss, vv, one, rem;
        longint     nv, np, nq, nt, nr, ng, nb;
        logic [3:0] sec;
        rgb_t       res;
        hh  = longint'(h);
        ss  = longint'(s);
        vv  = longint'(v);
        one = FRAC_ONE * SPAN;
        sec = 4'(hh / SPAN);
        rem = hh % SPAN;
        nv  = vv * one;
        if (ss == 0)
        begin
            nr = nv;
            ng = nv;
            nb = nv;
        end
        else
        begin
            np = vv * ((FRAC_ONE - ss) * SPAN);
            nq = vv * (one - ss * rem);
            nt = vv * (one - ss * (SPAN - rem));
            case (sec)
                hsvrgb_pkg::SEC_0: begin nr = nv; ng = nt; nb = np; end
                hsvrgb_pkg::SEC_1: begin nr = nq; ng = nv; nb = np; end
                hsvrgb_pkg::SEC_2: begin nr = np; ng = nv; nb = nt; end
                hsvrgb_pkg::SEC_3: begin nr = np; ng = nq; nb = nv; end
                hsvrgb_pkg::SEC_4: begin nr = nt; ng = np; nb = nv; end
                default:           begin nr = nv; ng = np; nb = nq; end
            endcase
        end
        res.red   = scale_channel(nr);
        res.green = scale_channel(ng);
        res.blue  = scale_channel(nb);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // result check first, then record the transaction accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (rgb_expected_q.size() == 0)
                    report_mismatch("result with nothing pending", 1, 0);
                else
                begin
                    oldest_rgb = rgb_expected_q.pop_front();
                    if (red !== oldest_rgb.red)
                        report_mismatch("red", red, oldest_rgb.red);
                    if (green !== oldest_rgb.green)
                        report_mismatch("green", green, oldest_rgb.green);
                    if (blue !== oldest_rgb.blue)
                        report_mismatch("blue", blue, oldest_rgb.blue);
                end
            end
            if (start && !busy)
                rgb_expected_q.push_back(predict_rgb(hue, saturation, brightness));
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("hsv_to_rgb_converter_core test failed");
            $finish;
        end
    end

    task automatic drive_hsv(input logic [14:0] h, input logic [16:0] s,
                             input logic [16:0] v, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (rgb_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_zero_saturation();
        drive_hsv(15'd0, 17'd0, 17'd0, 9);
        drive_hsv(15'd23040, 17'd0, 17'd65536, 9);
        drive_hsv(15'd1234, 17'd0, 17'd131071, 9);
        drive_hsv(15'd32767, 17'd0, 17'd32768, 9);
    endtask

    task automatic test_sector_boundaries();
        drive_hsv(15'd0, 17'd65536, 17'd65536, 9);
        drive_hsv(15'd3839, 17'd65536, 17'd65536, 9);
        drive_hsv(15'd3840, 17'd65536, 17'd65536, 9);
        drive_hsv(15'd7680, 17'd65536, 17'd65536, 9);
        drive_hsv(15'd11520, 17'd65536, 17'd65536, 9);
        drive_hsv(15'd15360, 17'd65536, 17'd65536, 9);
        drive_hsv(15'd19200, 17'd65536, 17'd65536, 9);
        drive_hsv(15'd23039, 17'd65536, 17'd65536, 9);
    endtask

    // 360 degrees and codes above fall into the last sector
    task automatic test_hue_wrap();
        drive_hsv(15'd23040, 17'd40000, 17'd50000, 9);
        drive_hsv(15'd26880, 17'd40000, 17'd50000, 9);
        drive_hsv(15'd32767, 17'd40000, 17'd50000, 9);
    endtask

    task automatic test_out_of_range();
        drive_hsv(15'd1920, 17'd131071, 17'd65536, 9);
        drive_hsv(15'd5000, 17'd65537, 17'd131071, 9);
        drive_hsv(15'd32767, 17'd131071, 17'd131071, 9);
        drive_hsv(15'd0, 17'd1, 17'd1, 9);
        drive_hsv(15'd12345, 17'd65536, 17'd131071, 9);
    endtask

    task automatic test_random_stream(input int count, input int idle_pct);
        logic [14:0] h;
        logic [16:0] s;
        logic [16:0] v;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(9);
            h = (pick == 0) ? 15'($urandom_range(32767)) : 15'($urandom_range(23040));
            pick = $urandom_range(9);
            case (pick)
                0:       s = 17'($urandom_range(131071));
                1:       s = 17'd0;
                2:       s = 17'd65536;
                default: s = 17'($urandom_range(65536));
            endcase
            pick = $urandom_range(9);
            case (pick)
                0:       v = 17'($urandom_range(131071));
                1:       v = 17'd0;
                2:       v = 17'd65536;
                default: v = 17'($urandom_range(65536));
            endcase
            drive_hsv(h, s, v, idle_pct);
            if (i % 100 == 99)
                wait_all_results();
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        hue            = '0;
        saturation     = '0;
        brightness     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_saturation();
        test_sector_boundaries();
        test_hue_wrap();
        test_out_of_range();
        wait_all_results();

        test_random_stream(170, 9);
        wait_all_results();
        test_random_stream(170, 55);
        wait_all_results();
        test_random_stream(170, 0);
        wait_all_results();

        if (mismatch_count == 0)
            $display("hsv_to_rgb_converter_core test passed");
        else
            $display("hsv_to_rgb_converter_core test failed");
        $finish;
    end

endmodule
